[hdl/pipt_pkg.sv]
// shared constants and types for the point-in-polygon tester
`default_nettype none
package pipt_pkg;
    localparam int MaxVertices = 256;
    localparam int CoordBits   = 24;
    localparam int SlotBits    = $clog2(MaxVertices);
    localparam int CountBits   = $clog2(MaxVertices + 1);
    localparam int DiffBits    = CoordBits + 1;
    localparam int ProdBits    = 2 * DiffBits;
    localparam int QueueDepth  = 2;
    localparam int QueueBits   = $clog2(QueueDepth);

    localparam logic CmdLoad  = 1'b0;
    localparam logic CmdQuery = 1'b1;

    localparam int RegVertexCount    = 0;
    localparam int RegBoundaryClosed = 1;

    typedef logic signed [CoordBits-1:0] t_coord;

    typedef struct packed {
        logic   is_query;
        logic   [SlotBits-1:0] slot;
        t_coord x;
        t_coord y;
    } t_request;
endpackage
`default_nettype wire

[hdl/pipt_front.sv]
// front end: takes requests and queues them for the edge walker
`default_nettype none
module pipt_front (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_cmd,
    input  wire logic [pipt_pkg::SlotBits-1:0] i_vertex_slot,
    input  wire pipt_pkg::t_coord i_coord_x,
    input  wire pipt_pkg::t_coord i_coord_y,
    output logic o_busy,
    input  wire logic i_pop,
    output logic o_valid,
    output pipt_pkg::t_request o_req
);
    import pipt_pkg::*;

    t_request r_q [QueueDepth];
    logic [QueueBits-1:0] r_wp, r_rp;
    logic [QueueBits:0] r_cnt;
    logic push;

    assign o_busy  = (r_cnt == (QueueBits+1)'(QueueDepth));
    assign push    = i_start && !o_busy;
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].is_query <= (i_cmd == CmdQuery);
            r_q[r_wp].slot     <= i_vertex_slot;
            r_q[r_wp].x        <= i_coord_x;
            r_q[r_wp].y        <= i_coord_y;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QueueBits+1)'(push) - (QueueBits+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

[hdl/pipt_back.sv]
// back end: vertex memory and the edge walker, one edge per cycle
`default_nettype none
module pipt_back (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire pipt_pkg::t_request i_req,
    output logic o_pop,
    input  wire logic [pipt_pkg::CountBits-1:0] i_vertex_count,
    input  wire logic i_boundary_closed,
    output logic o_done,
    output logic o_is_inside,
    output logic o_on_edge
);
    import pipt_pkg::*;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StRead = 2'd1;
    localparam logic [1:0] StEval = 2'd2;
    localparam logic [1:0] StDone = 2'd3;

    logic [2*CoordBits-1:0] r_mem [MaxVertices];
    logic [2*CoordBits-1:0] r_rd;
    logic [1:0] r_state, n_state;
    logic [SlotBits-1:0] r_idx, rd_addr;
    logic [CountBits-1:0] r_n, r_cnt;
    t_coord r_px, r_py, r_xj, r_yj;
    logic r_par, r_edge;

    // pipeline stage 1 registers (products)
    logic signed [ProdBits-1:0] r_p1, r_p2, r_q1, r_q2;
    logic r_deg, r_veq, r_box, r_straddle, r_dypos, r_s1v;

    t_coord xi, yi;
    logic signed [DiffBits-1:0] dpx, dpy, ex, ey;
    logic [CountBits-1:0] n_eff;

    assign n_eff = (i_vertex_count > CountBits'(MaxVertices))
                 ? CountBits'(MaxVertices) : i_vertex_count;
    assign xi = t_coord'(r_rd[2*CoordBits-1:CoordBits]);
    assign yi = t_coord'(r_rd[CoordBits-1:0]);
    assign dpx = DiffBits'(r_px) - DiffBits'(xi);
    assign dpy = DiffBits'(r_py) - DiffBits'(yi);
    assign ex  = DiffBits'(r_xj) - DiffBits'(xi);
    assign ey  = DiffBits'(r_yj) - DiffBits'(yi);

    assign o_pop = i_valid && (r_state == StIdle);

    always_comb begin
        rd_addr = r_idx;
        if (o_pop) rd_addr = i_req.is_query ? SlotBits'(n_eff - 1'b1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_req.is_query) r_mem[i_req.slot] <= {i_req.x, i_req.y};
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            StIdle: if (o_pop && i_req.is_query)
                        n_state = (n_eff == '0) ? StDone : StRead;
            StRead: n_state = StEval;
            StEval: if (r_cnt == r_n && !r_s1v) n_state = StDone;
            StDone: n_state = StIdle;
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_s1v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1v <= (r_state == StEval) && (r_cnt != r_n);
        end
        if (o_pop) begin
            r_px <= i_req.x;
            r_py <= i_req.y;
            r_n <= n_eff;
            r_cnt <= '0;
            r_idx <= '0;
            r_par <= 1'b0;
            r_edge <= 1'b0;
        end
        if (r_state == StRead) begin
            // first read gives the last vertex, the closing one
            r_xj <= xi;
            r_yj <= yi;
            r_idx <= r_idx + 1'b1;
        end
        if (r_state == StEval && r_cnt != r_n) begin
            r_p1 <= dpx * ey;      // on-edge cross product
            r_p2 <= dpy * ex;
            r_q1 <= dpx * ey;      // crossing compare
            r_q2 <= ex * dpy;
            r_deg <= (ex == '0) && (ey == '0);
            r_veq <= (dpx == '0) && (dpy == '0);
            r_box <= ((r_px >= xi && r_px <= r_xj) || (r_px <= xi && r_px >= r_xj))
                  && ((r_py >= yi && r_py <= r_yj) || (r_py <= yi && r_py >= r_yj));
            r_straddle <= (yi > r_py) != (r_yj > r_py);
            r_dypos <= ey > 0;
            r_xj <= xi;
            r_yj <= yi;
            r_idx <= r_idx + 1'b1;
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_s1v) begin
            if (r_deg ? r_veq : (r_p1 == r_p2 && r_box)) r_edge <= 1'b1;
            if (r_straddle && (r_dypos ? (r_q1 < r_q2) : (r_q1 > r_q2)))
                r_par <= !r_par;
        end
    end

    assign o_done = (r_state == StDone);
    assign o_on_edge = r_edge && (r_n != '0);
    assign o_is_inside = (r_n == '0) ? 1'b0 : (r_edge ? i_boundary_closed : r_par);
endmodule
`default_nettype wire

[hdl/point_in_polygon_test.sv]
// top level of the point-in-polygon tester
// Load requests write one vertex and give no result. A query walks every edge
// of the polygon, one edge per cycle through the vertex memory read port. Its
// result is a one-cycle o_done strobe. The request passes through the request
// queue, one read of the closing vertex, the edge walk, one product stage and
// the done state; with no vertices it goes straight to the done state.
// The walker takes no new request while a query runs. Loads leave the queue
// at one per cycle while the walker is idle. Two requests queue ahead of the
// walker, and busy rises when the queue is full. The receiver cannot stall
// results.
`default_nettype none
module point_in_polygon_test (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic busy,
    input  wire logic i_cmd,
    input  wire logic [pipt_pkg::SlotBits-1:0] i_vertex_slot,
    input  wire pipt_pkg::t_coord i_coord_x,
    input  wire pipt_pkg::t_coord i_coord_y,
    output logic o_done,
    output logic o_is_inside,
    output logic o_on_edge,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import pipt_pkg::*;

    logic [CountBits-1:0] r_vertex_count;
    logic r_boundary_closed;
    logic q_valid, q_pop;
    t_request q_req;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_boundary_closed <= 1'b1;
        end else if (wr) begin
            if (paddr[2] == 1'(RegVertexCount)) r_vertex_count <= pwdata[CountBits-1:0];
            else r_boundary_closed <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == 1'(RegBoundaryClosed)) prdata[0] = r_boundary_closed;
        else prdata[CountBits-1:0] = r_vertex_count;
    end

    pipt_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_cmd, .i_vertex_slot,
        .i_coord_x, .i_coord_y, .o_busy(busy), .i_pop(q_pop),
        .o_valid(q_valid), .o_req(q_req)
    );

    pipt_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_req(q_req), .o_pop(q_pop),
        .i_vertex_count(r_vertex_count), .i_boundary_closed(r_boundary_closed),
        .o_done, .o_is_inside, .o_on_edge
    );
endmodule
`default_nettype wire

[hdl/pipt_checker.sv]
// port-level checks for the point-in-polygon tester
`default_nettype none
module pipt_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic busy,
    input wire logic o_done,
    input wire logic o_is_inside,
    input wire logic o_on_edge,
    input wire logic pready
);
    a_pready: assert property (@(posedge i_clk) pready) else $error("pready low");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("back-to-back results");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown({o_is_inside, o_on_edge})) else $error("unknown result");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !busy && !o_done)
        else $error("not idle after reset");
endmodule
bind point_in_polygon_test pipt_checker u_chk (.*);
`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the point-in-polygon tester
`timescale 1ns / 100ps
module tb_top;
    import pipt_pkg::*;

    typedef struct {
        logic   cmd;
        logic   [SlotBits-1:0] slot;
        t_coord x;
        t_coord y;
    } t_item;

    typedef struct {
        logic is_inside;
        logic on_edge;
    } t_verdict;

    localparam int StallLimit = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cmd = 1'b0;
    logic [SlotBits-1:0] i_vertex_slot = '0;
    t_coord i_coord_x = '0;
    t_coord i_coord_y = '0;
    logic o_done, o_is_inside, o_on_edge;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    point_in_polygon_test dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic signed [CoordBits-1:0] poly_x [MaxVertices];
    logic signed [CoordBits-1:0] poly_y [MaxVertices];
    int  n_vertices = 0;
    bit  closed_mode = 1'b1;

    t_item    pending_requests[$];
    t_verdict expected_verdicts[$];
    int  failures = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;

    function automatic t_verdict locate_point(t_coord px, t_coord py);
        t_verdict r;
        bit parity, on_border;
        int j;
        logic signed [63:0] xi, yi, xj, yj, qx, qy, dx, dy;
        logic signed [127:0] lhs, rhs;
        parity = 0;
        on_border = 0;
        qx = px;
        qy = py;
        for (int i = 0; i < n_vertices; i++) begin
            j = (i == 0) ? n_vertices - 1 : i - 1;
            xi = poly_x[i]; yi = poly_y[i]; xj = poly_x[j]; yj = poly_y[j];
            dx = xj - xi;
            dy = yj - yi;
            if (dx == 0 && dy == 0) begin
                if (qx == xi && qy == yi) on_border = 1;
            end else begin
                lhs = (qx - xi) * dy;
                rhs = (qy - yi) * dx;
                if (lhs == rhs
                        && qx >= (xi < xj ? xi : xj) && qx <= (xi < xj ? xj : xi)
                        && qy >= (yi < yj ? yi : yj) && qy <= (yi < yj ? yj : yi))
                    on_border = 1;
            end
            if ((yi > qy) != (yj > qy)) begin
                lhs = (qx - xi) * dy;
                rhs = dx * (qy - yi);
                if (dy > 0 ? lhs < rhs : lhs > rhs) parity = !parity;
            end
        end
        r.on_edge = on_border;
        r.is_inside = on_border ? closed_mode : parity;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                if (pending_requests[0].cmd == CmdLoad) begin
                    poly_x[pending_requests[0].slot] = pending_requests[0].x;
                    poly_y[pending_requests[0].slot] = pending_requests[0].y;
                end else begin
                    expected_verdicts.push_back(locate_point(pending_requests[0].x,
                                                             pending_requests[0].y));
                end
                void'(pending_requests.pop_front());
            end
            if (!(start && busy)) begin
                if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
                    start <= 1'b1;
                    i_cmd <= pending_requests[0].cmd;
                    i_vertex_slot <= pending_requests[0].slot;
                    i_coord_x <= pending_requests[0].x;
                    i_coord_y <= pending_requests[0].y;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n) begin
            if ((start && !busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_done) begin
                if (expected_verdicts.size() == 0) begin
                    $error("unexpected result");
                    failures++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_is_inside !== want.is_inside) begin
                        $error("is_inside: expected %0b got %0b", want.is_inside, o_is_inside);
                        failures++;
                    end
                    if (o_on_edge !== want.on_edge) begin
                        $error("on_edge: expected %0b got %0b", want.on_edge, o_on_edge);
                        failures++;
                    end
                end
            end
            if (idle_cycles >= StallLimit) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input int index, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * index); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (index == RegVertexCount) n_vertices = value[8:0] > MaxVertices ? MaxVertices
                                                                     : value[8:0];
        else closed_mode = value[0];
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || expected_verdicts.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic add_request(input logic cmd, input int slot, input int x, input int y);
        t_item it;
        it.cmd = cmd;
        it.slot = slot[SlotBits-1:0];
        it.x = x[CoordBits-1:0];
        it.y = y[CoordBits-1:0];
        pending_requests.push_back(it);
    endtask

    function automatic int rand_coord(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // query near the polygon: on vertices, on edge midpoints, nearby, or at random points
    task automatic add_query(input int count, input int span);
        int k, m;
        k = $urandom_range(count - 1);
        m = (k == 0) ? count - 1 : k - 1;
        case ($urandom_range(4))
            0: add_request(CmdQuery, $urandom, poly_x[k], poly_y[k]);
            1: add_request(CmdQuery, $urandom, (poly_x[k] + poly_x[m]) >>> 1,
                           (poly_y[k] + poly_y[m]) >>> 1);
            2: add_request(CmdQuery, $urandom, poly_x[k] + rand_coord(2),
                           poly_y[k] + rand_coord(2));
            3: add_request(CmdQuery, $urandom, $urandom, $urandom);
            default: add_request(CmdQuery, $urandom, rand_coord(span), rand_coord(span));
        endcase
    endtask

    initial begin
        int count, span, sent;
        logic signed [CoordBits-1:0] sx [MaxVertices];
        logic signed [CoordBits-1:0] sy [MaxVertices];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: square with extreme corners, then queries
        write_reg(RegVertexCount, 4);
        write_reg(RegBoundaryClosed, 1);
        add_request(CmdLoad, 0, -8388608, -8388608);
        add_request(CmdLoad, 1, 8388607, -8388608);
        add_request(CmdLoad, 2, 8388607, 8388607);
        add_request(CmdLoad, 3, -8388608, 8388607);
        add_request(CmdQuery, 0, 0, 0);
        add_request(CmdQuery, 0, -8388608, -8388608);
        add_request(CmdQuery, 0, 8388607, 0);
        add_request(CmdQuery, 0, -8388608, 100);
        add_request(CmdLoad, 5, 7, 7);
        add_request(CmdLoad, 255, -1, -1);
        drain();
        write_reg(RegBoundaryClosed, 0);
        add_request(CmdQuery, 0, 8388607, 8388607);
        add_request(CmdQuery, 0, 5, -8388608);
        add_request(CmdQuery, 0, 1, 1);
        // zero-length edge: duplicate vertex
        add_request(CmdLoad, 3, 8388607, 8388607);
        add_request(CmdQuery, 0, 8388607, 8388607);
        add_request(CmdQuery, 0, 8388606, 8388607);
        drain();
        write_reg(RegVertexCount, 0);
        add_request(CmdQuery, 0, 0, 0);
        drain();
        write_reg(RegVertexCount, 1);
        add_request(CmdQuery, 0, -8388608, -8388608);
        add_request(CmdQuery, 0, 3, 3);
        drain();
        // oversized count clamps to the full memory; fill every slot first
        for (int s = 0; s < MaxVertices; s++) add_request(CmdLoad, s, rand_coord(1000),
                                                          rand_coord(1000));
        drain();
        write_reg(RegVertexCount, 511);
        add_request(CmdQuery, 0, 0, 0);
        add_request(CmdQuery, 0, 8388607, -8388608);
        drain();

        // random phases
        sent = 0;
        while (sent < 1330) begin
            calm = ($urandom_range(5) == 0);
            count = ($urandom_range(9) == 0) ? $urandom_range(MaxVertices, 3)
                                             : $urandom_range(12, 1);
            span = ($urandom_range(2) == 0) ? 8388607 : $urandom_range(20, 2);
            write_reg(RegVertexCount, count);
            write_reg(RegBoundaryClosed, $urandom_range(1));
            for (int s = 0; s < count; s++) begin
                sx[s] = rand_coord(span);
                sy[s] = rand_coord(span);
                add_request(CmdLoad, s, sx[s], sy[s]);
                sent++;
            end
            drain();
            for (int q = 0; q < (count > 40 ? 4 : 25); q++) begin
                if ($urandom_range(15) == 0) begin
                    add_request(CmdLoad, $urandom_range(count - 1), $urandom, $urandom);
                    sent++;
                    drain();
                end
                add_query(count, span);
                sent++;
            end
            drain();
        end

        if (failures == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule

[filelist.f]
hdl/pipt_pkg.sv
hdl/pipt_front.sv
hdl/pipt_back.sv
hdl/point_in_polygon_test.sv
hdl/pipt_checker.sv
tb/tb_top.sv
